// ----- design/qvr_pkg.sv -----
`default_nettype none
package qvr_pkg;

  localparam int QW = 16;  // quaternion component, Q2.14
  localparam int VW = 32;  // vector and result component, Q16.16
  localparam int PW = 32;  // quaternion component products
  localparam int MW = 34;  // rotation matrix entries
  localparam int HW = 50;  // matrix entry times upper vector half
  localparam int LW = 51;  // matrix entry times lower vector half
  localparam int AW = 52;  // row sum of upper partials
  localparam int BW = 53;  // row sum of lower partials
  localparam int TW = 70;  // full row total
  localparam int FS = 28;  // fraction bits dropped by rounding
  localparam int RW = TW - FS;
  localparam int STAGES = 5;

endpackage
`default_nettype wire

// ----- design/quaternion_vector_rotate_core.sv -----
// Quaternion vector rotation, vector part of q * (0, v) * conj(q), fixed point.
// Five register stages: products, matrix, split partials, row sums and clipped result.
// Throughput: one item per cycle; each stage holds only while the stage after it is full
// and stalled, so bubbles fill; the input closes only when the whole pipe is stalled.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
`default_nettype none
module quaternion_vector_rotate_core
  import qvr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire logic signed [QW-1:0] quat_w,
  input  wire logic signed [QW-1:0] quat_x,
  input  wire logic signed [QW-1:0] quat_y,
  input  wire logic signed [QW-1:0] quat_z,
  input  wire logic signed [VW-1:0] vec_x,
  input  wire logic signed [VW-1:0] vec_y,
  input  wire logic signed [VW-1:0] vec_z,
  output logic                      rot_valid,
  input  wire logic                 rot_ready,
  output logic signed [VW-1:0]      rot_x,
  output logic signed [VW-1:0]      rot_y,
  output logic signed [VW-1:0]      rot_z,
  output logic                      saturated
);

  localparam logic signed [RW-1:0] RMAX = RW'(32'sh7fff_ffff);
  localparam logic signed [RW-1:0] RMIN = ~RMAX;
  localparam logic signed [TW-1:0] HALF = TW'(1) <<< (FS - 1);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // stage 1: component products
  logic signed [PW-1:0] pww, pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [VW-1:0] v1 [3];
  // stage 2: matrix
  logic signed [MW-1:0] m2 [9];
  logic signed [VW-1:0] v2 [3];
  // stage 3: split partial products
  logic signed [HW-1:0] ph3 [9];
  logic signed [LW-1:0] pl3 [9];
  // stage 4: row sums
  logic signed [AW-1:0] a4 [3];
  logic signed [BW-1:0] b4 [3];
  // stage 5 logic
  logic signed [TW-1:0] tot [3];
  logic signed [RW-1:0] rnd [3];
  logic signed [VW-1:0] clip [3];
  logic [2:0]           hit;

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || rot_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign item_ready = en[0];
  assign rot_valid  = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= item_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pww <= PW'(quat_w) * PW'(quat_w);
      pxx <= PW'(quat_x) * PW'(quat_x);
      pyy <= PW'(quat_y) * PW'(quat_y);
      pzz <= PW'(quat_z) * PW'(quat_z);
      pxy <= PW'(quat_x) * PW'(quat_y);
      pxz <= PW'(quat_x) * PW'(quat_z);
      pyz <= PW'(quat_y) * PW'(quat_z);
      pwx <= PW'(quat_w) * PW'(quat_x);
      pwy <= PW'(quat_w) * PW'(quat_y);
      pwz <= PW'(quat_w) * PW'(quat_z);
      v1[0] <= vec_x;
      v1[1] <= vec_y;
      v1[2] <= vec_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m2[0] <= MW'(pww) + MW'(pxx) - MW'(pyy) - MW'(pzz);
      m2[1] <= (MW'(pxy) - MW'(pwz)) <<< 1;
      m2[2] <= (MW'(pxz) + MW'(pwy)) <<< 1;
      m2[3] <= (MW'(pxy) + MW'(pwz)) <<< 1;
      m2[4] <= MW'(pww) - MW'(pxx) + MW'(pyy) - MW'(pzz);
      m2[5] <= (MW'(pyz) - MW'(pwx)) <<< 1;
      m2[6] <= (MW'(pxz) - MW'(pwy)) <<< 1;
      m2[7] <= (MW'(pyz) + MW'(pwx)) <<< 1;
      m2[8] <= MW'(pww) - MW'(pxx) - MW'(pyy) + MW'(pzz);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph3[i*3+j] <= HW'(m2[i*3+j]) * HW'(signed'(v2[j][VW-1:VW/2]));
          pl3[i*3+j] <= LW'(m2[i*3+j]) * LW'(signed'({1'b0, v2[j][VW/2-1:0]}));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        a4[i] <= AW'(ph3[i*3]) + AW'(ph3[i*3+1]) + AW'(ph3[i*3+2]);
        b4[i] <= BW'(pl3[i*3]) + BW'(pl3[i*3+1]) + BW'(pl3[i*3+2]);
      end
    end
  end

  // round half up, then clip to 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (TW'(a4[i]) <<< (VW/2)) + TW'(b4[i]) + HALF;
      rnd[i] = tot[i][TW-1:FS];
      hit[i] = 1'b1;
      if (rnd[i] > RMAX) begin
        clip[i] = RMAX[VW-1:0];
      end else if (rnd[i] < RMIN) begin
        clip[i] = RMIN[VW-1:0];
      end else begin
        clip[i] = rnd[i][VW-1:0];
        hit[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rot_x     <= clip[0];
      rot_y     <= clip[1];
      rot_z     <= clip[2];
      saturated <= |hit;
    end
  end

endmodule
`default_nettype wire

// ----- design/qvr_checker.sv -----
`default_nettype none
module qvr_checker
  import qvr_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_ready,
  input wire logic                 rot_valid,
  input wire logic                 rot_ready,
  input wire logic signed [VW-1:0] rot_x,
  input wire logic signed [VW-1:0] rot_y,
  input wire logic signed [VW-1:0] rot_z,
  input wire logic                 saturated
);

  localparam logic [VW-1:0] SMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] SMIN = {1'b1, {(VW-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rot_valid && !rot_ready |=> rot_valid)
    else $error("result valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    rot_valid && !rot_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
      && $stable(saturated))
    else $error("stalled result changed");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    rot_valid && saturated |->
      (rot_x == SMAX || rot_x == SMIN || rot_y == SMAX || rot_y == SMIN
       || rot_z == SMAX || rot_z == SMIN))
    else $error("saturated flag without a clipped component");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rot_valid)
    else $error("result valid right after reset");

  a_ready_open: assert property (@(posedge clk) disable iff (rst)
    !rot_valid |-> item_ready)
    else $error("input blocked while output stage empty");

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (.*);
`default_nettype wire
